@@ rtl/sbqe_pkg.sv @@
package sbqe_pkg;

  localparam int MAX_PROCS_DEF = 32;

  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int SLOT_W   = 5;
  localparam int PID_W    = 31;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
  localparam logic [OP_W-1:0] OP_RM_HEAD  = 3'd1;
  localparam logic [OP_W-1:0] OP_RM_PROC  = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK     = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND_PID = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND_SEM = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFREE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PKEY,   // key of the slot being removed is on the read port
    S_SRD,    // key scan: issue read of descriptor key
    S_SCMP,   // key scan: compare
    S_HT,     // head and tail of the hit descriptor are available
    S_NXT,    // link of the head is available
    S_TRV,    // walking the queue for the predecessor
    S_UNL,    // link of the removed slot is available
    S_ALLOC,  // head of the free FIFO is available
    S_PRD,    // pid scan: issue read
    S_PCMP,   // pid scan: compare
    S_PK4     // key of the slot found by pid is available
  } state_t;

endpackage

@@ rtl/sbqe_ram.sv @@
module sbqe_ram #(
  parameter int W  = 8,
  parameter int D  = 32,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/semaphore_blocked_queue_engine.sv @@
// A transaction refused on entry is answered straight from idle; otherwise the result
//   waits on the pid scan (a compare only for blocked slots), the descriptor key scan (a
//   compare only for active descriptors) and the queue walk of remove-process.
// Throughput: one transaction at a time; busy is low again in the cycle of the strobe.
// Reset (rst_n low, synchronous): all descriptors free, no slot blocked, free FIFO in order.
// The receiver cannot stall: out_valid is high for exactly one cycle per transaction.
module semaphore_blocked_queue_engine #(
  parameter int MAX_PROCS = sbqe_pkg::MAX_PROCS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [sbqe_pkg::OP_W-1:0]      in_op,
  input  logic [sbqe_pkg::KEY_W-1:0]     in_sem_key,
  input  logic [sbqe_pkg::SLOT_W-1:0]    in_proc_slot,
  input  logic [sbqe_pkg::PID_W-1:0]     in_proc_pid,
  output logic                           out_valid,
  output logic [sbqe_pkg::STATUS_W-1:0]  out_status,
  output logic [sbqe_pkg::SLOT_W-1:0]    out_result_slot,
  output logic [sbqe_pkg::SLOT_W-1:0]    out_desc_index
);

  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam logic [IW-1:0] LAST = IW'(MAX_PROCS - 1);

  sbqe_pkg::state_t state_r, state_nxt;

  logic [sbqe_pkg::OP_W-1:0]  op_r, op_nxt;
  logic [sbqe_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [sbqe_pkg::PID_W-1:0] pid_r, pid_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] d_r, d_nxt;
  logic [IW-1:0] s_r, s_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] prev_r, prev_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic [IW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [MAX_PROCS-1:0] active_r, active_nxt;
  logic [MAX_PROCS-1:0] blocked_r, blocked_nxt;
  logic [MAX_PROCS-1:0] fv_r, fv_nxt;
  logic          fvld_r;
  logic [IW-1:0] faddr_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [sbqe_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [IW-1:0]                   out_slot_r, out_slot_nxt;
  logic [IW-1:0]                   out_desc_r, out_desc_nxt;

  // memory ports
  logic key_we, head_we, tail_we, next_we, pkey_we, pid_we, free_we;
  logic [IW-1:0] key_wa, head_wa, tail_wa, next_wa, pkey_wa, pid_wa, free_wa;
  logic [IW-1:0] head_wd, tail_wd, next_wd, free_wd;
  logic [IW-1:0] pkey_ra, next_ra;
  logic [sbqe_pkg::KEY_W-1:0] key_q, pkey_q;
  logic [sbqe_pkg::PID_W-1:0] pid_q;
  logic [IW-1:0] head_q, tail_q, next_q, free_q, free_d;

  logic [IW-1:0] in_slot_i;
  logic          in_slot_ok;
  logic          key_hit, pid_hit, idx_last, srch_nf, trv_go, trv_ok;
  logic [CW:0]   wr_sum;
  logic [IW-1:0] wr_ptr;

  sbqe_ram #(.W(sbqe_pkg::KEY_W), .D(MAX_PROCS)) u_desc_key (
    .clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_r), .raddr(idx_r), .rd_data(key_q));
  sbqe_ram #(.W(IW), .D(MAX_PROCS)) u_desc_head (
    .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(idx_r),
    .rd_data(head_q));
  sbqe_ram #(.W(IW), .D(MAX_PROCS)) u_desc_tail (
    .clk(clk), .we(tail_we), .waddr(tail_wa), .wdata(tail_wd), .raddr(idx_r),
    .rd_data(tail_q));
  sbqe_ram #(.W(IW), .D(MAX_PROCS)) u_proc_next (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd), .raddr(next_ra),
    .rd_data(next_q));
  sbqe_ram #(.W(sbqe_pkg::KEY_W), .D(MAX_PROCS)) u_proc_key (
    .clk(clk), .we(pkey_we), .waddr(pkey_wa), .wdata(key_r), .raddr(pkey_ra),
    .rd_data(pkey_q));
  sbqe_ram #(.W(sbqe_pkg::PID_W), .D(MAX_PROCS)) u_proc_pid (
    .clk(clk), .we(pid_we), .waddr(pid_wa), .wdata(pid_r), .raddr(idx_r), .rd_data(pid_q));
  sbqe_ram #(.W(IW), .D(MAX_PROCS)) u_free_fifo (
    .clk(clk), .we(free_we), .waddr(free_wa), .wdata(free_wd), .raddr(rd_r),
    .rd_data(free_q));

  assign in_slot_i  = IW'(in_proc_slot);
  assign in_slot_ok = 9'(in_proc_slot) < 9'(MAX_PROCS);
  assign key_hit    = key_q == key_r;
  assign pid_hit    = pid_q == pid_r;
  assign idx_last   = idx_r == LAST;
  assign srch_nf    = ((state_r == sbqe_pkg::S_SRD) && !active_r[idx_r] && idx_last) ||
                      ((state_r == sbqe_pkg::S_SCMP) && !key_hit && idx_last);
  assign trv_go     = (next_q != slot_r) && (prev_r != tail_r) &&
                      (steps_r < CW'(MAX_PROCS));
  assign trv_ok     = (next_q == slot_r) && (prev_r != tail_r);
  // an entry never written since reset still holds its own index
  assign free_d     = fvld_r ? free_q : faddr_r;
  assign wr_sum     = (CW+1)'(rd_r) + (CW+1)'(cnt_r);
  assign wr_ptr     = (wr_sum >= (CW+1)'(MAX_PROCS)) ? IW'(wr_sum - (CW+1)'(MAX_PROCS))
                                                     : IW'(wr_sum);
  assign pkey_ra    = (state_r == sbqe_pkg::S_IDLE) ? in_slot_i : idx_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbqe_pkg::S_IDLE: begin
        if (start) begin
          case (in_op)
            sbqe_pkg::OP_INSERT:
              state_nxt = (in_slot_ok && !blocked_r[in_slot_i]) ? sbqe_pkg::S_SRD
                                                                : sbqe_pkg::S_IDLE;
            sbqe_pkg::OP_RM_HEAD, sbqe_pkg::OP_PEEK, sbqe_pkg::OP_FIND_SEM:
              state_nxt = sbqe_pkg::S_SRD;
            sbqe_pkg::OP_RM_PROC:
              state_nxt = (in_slot_ok && blocked_r[in_slot_i]) ? sbqe_pkg::S_PKEY
                                                               : sbqe_pkg::S_IDLE;
            sbqe_pkg::OP_FIND_PID: state_nxt = sbqe_pkg::S_PRD;
            default:               state_nxt = sbqe_pkg::S_IDLE;
          endcase
        end
      end
      sbqe_pkg::S_PKEY, sbqe_pkg::S_PK4: state_nxt = sbqe_pkg::S_SRD;
      sbqe_pkg::S_SRD, sbqe_pkg::S_SCMP: begin
        if (srch_nf) begin
          state_nxt = (op_r == sbqe_pkg::OP_INSERT && cnt_r != '0) ? sbqe_pkg::S_ALLOC
                                                                   : sbqe_pkg::S_IDLE;
        end else if (state_r == sbqe_pkg::S_SRD) begin
          state_nxt = active_r[idx_r] ? sbqe_pkg::S_SCMP : sbqe_pkg::S_SRD;
        end else if (key_hit) begin
          state_nxt = (op_r == sbqe_pkg::OP_FIND_SEM || op_r == sbqe_pkg::OP_FIND_PID)
                      ? sbqe_pkg::S_IDLE : sbqe_pkg::S_HT;
        end else begin
          state_nxt = sbqe_pkg::S_SRD;
        end
      end
      sbqe_pkg::S_HT: begin
        if (op_r == sbqe_pkg::OP_RM_HEAD) begin
          state_nxt = (tail_q == head_q) ? sbqe_pkg::S_IDLE : sbqe_pkg::S_NXT;
        end else if (op_r == sbqe_pkg::OP_RM_PROC) begin
          if (head_q == slot_r) begin
            state_nxt = (tail_q == slot_r) ? sbqe_pkg::S_IDLE : sbqe_pkg::S_NXT;
          end else begin
            state_nxt = sbqe_pkg::S_TRV;
          end
        end else begin
          state_nxt = sbqe_pkg::S_IDLE;
        end
      end
      sbqe_pkg::S_TRV: begin
        if (trv_go) begin
          state_nxt = sbqe_pkg::S_TRV;
        end else begin
          state_nxt = trv_ok ? sbqe_pkg::S_UNL : sbqe_pkg::S_IDLE;
        end
      end
      sbqe_pkg::S_PRD: begin
        if (blocked_r[idx_r]) begin
          state_nxt = sbqe_pkg::S_PCMP;
        end else begin
          state_nxt = idx_last ? sbqe_pkg::S_IDLE : sbqe_pkg::S_PRD;
        end
      end
      sbqe_pkg::S_PCMP: begin
        if (pid_hit) begin
          state_nxt = sbqe_pkg::S_PK4;
        end else begin
          state_nxt = idx_last ? sbqe_pkg::S_IDLE : sbqe_pkg::S_PRD;
        end
      end
      sbqe_pkg::S_NXT, sbqe_pkg::S_UNL, sbqe_pkg::S_ALLOC: state_nxt = sbqe_pkg::S_IDLE;
      default: state_nxt = sbqe_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt      = op_r;
    key_nxt     = key_r;
    pid_nxt     = pid_r;
    slot_nxt    = slot_r;
    idx_nxt     = idx_r;
    d_nxt       = d_r;
    s_nxt       = s_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    prev_nxt    = prev_r;
    steps_nxt   = steps_r;
    rd_nxt      = rd_r;
    cnt_nxt     = cnt_r;
    active_nxt  = active_r;
    blocked_nxt = blocked_r;
    fv_nxt      = fv_r;
    key_we = 1'b0;  key_wa  = d_r;
    head_we = 1'b0; head_wa = d_r;    head_wd = slot_r;
    tail_we = 1'b0; tail_wa = d_r;    tail_wd = slot_r;
    next_we = 1'b0; next_wa = prev_r; next_wd = next_q;
    pkey_we = 1'b0; pkey_wa = slot_r;
    pid_we  = 1'b0; pid_wa  = slot_r;
    free_we = 1'b0; free_wa = wr_ptr; free_wd = d_r;
    next_ra = slot_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = sbqe_pkg::ST_NOTFOUND;
    out_slot_nxt   = '0;
    out_desc_nxt   = '0;

    unique case (state_r)
      sbqe_pkg::S_IDLE: begin
        if (start) begin
          op_nxt   = in_op;
          key_nxt  = in_sem_key;
          pid_nxt  = in_proc_pid;
          slot_nxt = in_slot_i;
          idx_nxt  = '0;
          if (state_nxt == sbqe_pkg::S_IDLE) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      sbqe_pkg::S_PKEY, sbqe_pkg::S_PK4: begin
        key_nxt = pkey_q;
        idx_nxt = '0;
      end
      sbqe_pkg::S_SRD, sbqe_pkg::S_SCMP: begin
        if (srch_nf) begin
          if (op_r == sbqe_pkg::OP_FIND_PID) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = sbqe_pkg::ST_OK;
            out_slot_nxt   = s_r;
          end else if (op_r == sbqe_pkg::OP_INSERT && cnt_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = sbqe_pkg::ST_NOFREE;
          end else if (op_r != sbqe_pkg::OP_INSERT) begin
            out_valid_nxt = 1'b1;
          end
        end else if (state_r == sbqe_pkg::S_SCMP && key_hit) begin
          d_nxt = idx_r;
          if (op_r == sbqe_pkg::OP_FIND_SEM || op_r == sbqe_pkg::OP_FIND_PID) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = sbqe_pkg::ST_OK;
            out_slot_nxt   = (op_r == sbqe_pkg::OP_FIND_PID) ? s_r : '0;
            out_desc_nxt   = idx_r;
          end
        end else if (state_r == sbqe_pkg::S_SCMP || !active_r[idx_r]) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      sbqe_pkg::S_HT: begin
        head_nxt  = head_q;
        tail_nxt  = tail_q;
        prev_nxt  = head_q;
        steps_nxt = '0;
        out_desc_nxt = d_r;
        case (op_r)
          sbqe_pkg::OP_INSERT: begin
            next_we = 1'b1; next_wa = tail_q; next_wd = slot_r;
            tail_we = 1'b1;
            pkey_we = 1'b1;
            pid_we  = 1'b1;
            blocked_nxt[slot_r] = 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = sbqe_pkg::ST_OK;
            out_slot_nxt   = slot_r;
          end
          sbqe_pkg::OP_PEEK: begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = sbqe_pkg::ST_OK;
            out_slot_nxt   = head_q;
          end
          sbqe_pkg::OP_RM_HEAD: begin
            next_ra = head_q;
            blocked_nxt[head_q] = 1'b0;
            if (tail_q == head_q) begin
              active_nxt[d_r] = 1'b0;
              if (cnt_r < CW'(MAX_PROCS)) begin
                free_we = 1'b1;
                fv_nxt[wr_ptr] = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
              out_valid_nxt  = 1'b1;
              out_status_nxt = sbqe_pkg::ST_OK;
              out_slot_nxt   = head_q;
            end
          end
          default: begin
            // remove process
            next_ra = (head_q == slot_r) ? slot_r : head_q;
            if (head_q == slot_r && tail_q == slot_r) begin
              active_nxt[d_r]     = 1'b0;
              blocked_nxt[slot_r] = 1'b0;
              if (cnt_r < CW'(MAX_PROCS)) begin
                free_we = 1'b1;
                fv_nxt[wr_ptr] = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
              out_valid_nxt  = 1'b1;
              out_status_nxt = sbqe_pkg::ST_OK;
              out_slot_nxt   = slot_r;
            end
          end
        endcase
      end
      sbqe_pkg::S_NXT: begin
        head_we = 1'b1;
        head_wd = next_q;
        if (op_r == sbqe_pkg::OP_RM_PROC) begin
          blocked_nxt[slot_r] = 1'b0;
        end
        out_valid_nxt  = 1'b1;
        out_status_nxt = sbqe_pkg::ST_OK;
        out_slot_nxt   = (op_r == sbqe_pkg::OP_RM_PROC) ? slot_r : head_r;
        out_desc_nxt   = d_r;
      end
      sbqe_pkg::S_TRV: begin
        if (trv_go) begin
          prev_nxt  = next_q;
          steps_nxt = steps_r + 1'b1;
          next_ra   = next_q;
        end else if (trv_ok) begin
          next_ra = slot_r;
        end else begin
          out_valid_nxt = 1'b1;
        end
      end
      sbqe_pkg::S_UNL: begin
        // unlink: predecessor takes over the removed slot's link
        next_we = 1'b1;
        tail_we = tail_r == slot_r;
        tail_wd = prev_r;
        blocked_nxt[slot_r] = 1'b0;
        out_valid_nxt  = 1'b1;
        out_status_nxt = sbqe_pkg::ST_OK;
        out_slot_nxt   = slot_r;
        out_desc_nxt   = d_r;
      end
      sbqe_pkg::S_ALLOC: begin
        d_nxt   = free_d;
        key_we  = 1'b1; key_wa  = free_d;
        head_we = 1'b1; head_wa = free_d;
        tail_we = 1'b1; tail_wa = free_d;
        pkey_we = 1'b1;
        pid_we  = 1'b1;
        active_nxt[free_d]  = 1'b1;
        blocked_nxt[slot_r] = 1'b1;
        rd_nxt  = (rd_r == LAST) ? '0 : rd_r + 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        out_valid_nxt  = 1'b1;
        out_status_nxt = sbqe_pkg::ST_OK;
        out_slot_nxt   = slot_r;
        out_desc_nxt   = free_d;
      end
      sbqe_pkg::S_PRD: begin
        if (!blocked_r[idx_r]) begin
          if (idx_last) begin
            out_valid_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      sbqe_pkg::S_PCMP: begin
        if (pid_hit) begin
          s_nxt = idx_r;
        end else if (idx_last) begin
          out_valid_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbqe_pkg::S_IDLE;
      rd_r        <= '0;
      cnt_r       <= CW'(MAX_PROCS);
      active_r    <= '0;
      blocked_r   <= '0;
      fv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_r        <= rd_nxt;
      cnt_r       <= cnt_nxt;
      active_r    <= active_nxt;
      blocked_r   <= blocked_nxt;
      fv_r        <= fv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    pid_r        <= pid_nxt;
    slot_r       <= slot_nxt;
    idx_r        <= idx_nxt;
    d_r          <= d_nxt;
    s_r          <= s_nxt;
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    prev_r       <= prev_nxt;
    steps_r      <= steps_nxt;
    fvld_r       <= fv_r[rd_r];
    faddr_r      <= rd_r;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_desc_r   <= out_desc_nxt;
  end

  assign busy            = state_r != sbqe_pkg::S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_slot = 5'(out_slot_r);
  assign out_desc_index  = 5'(out_desc_r);

`ifndef ASSERT_OFF
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");
  a_free_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_PROCS)) else $error("free count overflow");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sbqe_pkg::ST_OK |-> out_result_slot == '0 &&
    out_desc_index == '0) else $error("failed transaction with nonzero fields");
  a_alloc_had_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sbqe_pkg::S_ALLOC |-> cnt_r != '0) else $error("allocation from empty pool");
`endif

endmodule

@@ tb/sv/tb_semaphore_blocked_queue_engine.sv @@
module tb_semaphore_blocked_queue_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import sbqe_pkg::*;

  localparam int NP = MAX_PROCS_DEF;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
    logic [PID_W-1:0]  pid;
  } sem_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   rslot;
    logic [SLOT_W-1:0]   didx;
  } sem_resp_t;

  logic clk, rst_n, start, busy, out_valid;
  logic [OP_W-1:0] in_op;
  logic [KEY_W-1:0] in_sem_key;
  logic [SLOT_W-1:0] in_proc_slot;
  logic [PID_W-1:0] in_proc_pid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0] out_result_slot, out_desc_index;

  semaphore_blocked_queue_engine uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_sem_key(in_sem_key), .in_proc_slot(in_proc_slot),
    .in_proc_pid(in_proc_pid), .out_valid(out_valid), .out_status(out_status),
    .out_result_slot(out_result_slot), .out_desc_index(out_desc_index)
  );

  // shadow of the engine's state
  logic [KEY_W-1:0]  m_dkey [NP];
  logic              m_dact [NP];
  logic [SLOT_W-1:0] m_dhead [NP];
  logic [SLOT_W-1:0] m_dtail [NP];
  logic [SLOT_W-1:0] m_pnext [NP];
  logic [KEY_W-1:0]  m_pkey [NP];
  logic [PID_W-1:0]  m_pid [NP];
  logic              m_pblk [NP];
  logic [SLOT_W-1:0] m_free [NP];
  int                m_free_cnt, m_free_rd;

  sem_cmd_t  pending_cmds[$];
  sem_resp_t expected_resps[$];
  int errors = 0;
  int cycles = 0;
  int gap = 0;
  bit hold_off = 0;
  logic [KEY_W-1:0] key_pool [8];

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic report(input string what, input sem_resp_t got, input sem_resp_t exp);
    $display("mismatch %s: got st=%0d slot=%0d desc=%0d, exp st=%0d slot=%0d desc=%0d",
             what, got.status, got.rslot, got.didx, exp.status, exp.rslot, exp.didx);
    errors++;
  endtask

  function automatic int find_desc(input logic [KEY_W-1:0] k);
    for (int d = 0; d < NP; d++)
      if (m_dact[d] && m_dkey[d] == k) return d;
    return -1;
  endfunction

  function automatic void free_desc(input int d);
    m_dact[d] = 0;
    if (m_free_cnt < NP) begin
      m_free[(m_free_rd + m_free_cnt) % NP] = SLOT_W'(d);
      m_free_cnt++;
    end
  endfunction

  function automatic void reset_shadow();
    for (int i = 0; i < NP; i++) begin
      m_dact[i] = 0; m_pblk[i] = 0; m_free[i] = SLOT_W'(i);
      m_dkey[i] = '0; m_dhead[i] = '0; m_dtail[i] = '0;
      m_pnext[i] = '0; m_pkey[i] = '0; m_pid[i] = '0;
    end
    m_free_cnt = NP;
    m_free_rd = 0;
  endfunction

  function automatic sem_resp_t predict_queue_op(input sem_cmd_t c);
    sem_resp_t r;
    int d, s, prev, steps;
    r = '{ST_NOTFOUND, '0, '0};
    s = c.slot;
    case (c.op)
      OP_INSERT: begin
        if (s >= NP || m_pblk[s]) return r;
        d = find_desc(c.key);
        if (d >= 0) begin
          m_pnext[m_dtail[d]] = SLOT_W'(s);
          m_dtail[d] = SLOT_W'(s);
        end else begin
          if (m_free_cnt == 0) return '{ST_NOFREE, '0, '0};
          d = m_free[m_free_rd % NP];
          m_free_rd = (m_free_rd + 1) % NP;
          m_free_cnt--;
          m_dact[d] = 1; m_dkey[d] = c.key;
          m_dhead[d] = SLOT_W'(s); m_dtail[d] = SLOT_W'(s);
        end
        m_pblk[s] = 1; m_pkey[s] = c.key; m_pid[s] = c.pid;
        r = '{ST_OK, SLOT_W'(s), SLOT_W'(d)};
      end
      OP_RM_HEAD: begin
        d = find_desc(c.key);
        if (d < 0) return r;
        s = m_dhead[d];
        m_pblk[s] = 0;
        if (m_dtail[d] == s) free_desc(d);
        else m_dhead[d] = m_pnext[s];
        r = '{ST_OK, SLOT_W'(s), SLOT_W'(d)};
      end
      OP_RM_PROC: begin
        if (s >= NP || !m_pblk[s]) return r;
        d = find_desc(m_pkey[s]);
        if (d < 0) return r;
        if (m_dhead[d] == s) begin
          if (m_dtail[d] == s) free_desc(d);
          else m_dhead[d] = m_pnext[s];
        end else begin
          prev = m_dhead[d];
          steps = 0;
          while (m_pnext[prev] != s && prev != m_dtail[d] && steps < NP) begin
            prev = m_pnext[prev];
            steps++;
          end
          if (m_pnext[prev] != s || prev == m_dtail[d]) return r;
          m_pnext[prev] = m_pnext[s];
          if (m_dtail[d] == s) m_dtail[d] = SLOT_W'(prev);
        end
        m_pblk[s] = 0;
        r = '{ST_OK, SLOT_W'(s), SLOT_W'(d)};
      end
      OP_PEEK: begin
        d = find_desc(c.key);
        if (d >= 0) r = '{ST_OK, m_dhead[d], SLOT_W'(d)};
      end
      OP_FIND_PID: begin
        for (int i = 0; i < NP; i++)
          if (m_pblk[i] && m_pid[i] == c.pid) begin
            d = find_desc(m_pkey[i]);
            return '{ST_OK, SLOT_W'(i), d < 0 ? '0 : SLOT_W'(d)};
          end
      end
      OP_FIND_SEM: begin
        d = find_desc(c.key);
        if (d >= 0) r = '{ST_OK, '0, SLOT_W'(d)};
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void push_cmd(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                                   input logic [SLOT_W-1:0] s, input logic [PID_W-1:0] p);
    pending_cmds.push_back('{op, k, s, p});
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
      in_op <= '0; in_sem_key <= '0; in_proc_slot <= '0; in_proc_pid <= '0;
    end else if (start && !busy) begin
      expected_resps.push_back(predict_queue_op(pending_cmds.pop_front()));
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap == 0 && pending_cmds.size() != 0 && !hold_off) begin
        in_op <= pending_cmds[0].op; in_sem_key <= pending_cmds[0].key;
        in_proc_slot <= pending_cmds[0].slot; in_proc_pid <= pending_cmds[0].pid;
      end else begin
        start <= 0;
      end
    end else if (!start && pending_cmds.size() != 0) begin
      if (hold_off) begin
        if (expected_resps.size() == 0) hold_off = 0;
      end else if (gap > 0) begin
        gap--;
      end else begin
        start <= 1;
        in_op <= pending_cmds[0].op; in_sem_key <= pending_cmds[0].key;
        in_proc_slot <= pending_cmds[0].slot; in_proc_pid <= pending_cmds[0].pid;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    sem_resp_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_semaphore_blocked_queue_engine: FAIL");
      $finish;
    end
    if (rst_n && out_valid) begin
      got = '{out_status, out_result_slot, out_desc_index};
      if (expected_resps.size() == 0) begin
        report("unexpected", got, got);
      end else begin
        sem_resp_t exp;
        exp = expected_resps.pop_front();
        if (got.status !== exp.status) report("status", got, exp);
        else if (got.rslot !== exp.rslot) report("result_slot", got, exp);
        else if (got.didx !== exp.didx) report("desc_index", got, exp);
      end
    end
  end

  initial begin
    int op, s, n, sel;
    logic [KEY_W-1:0] k;
    rst_n = 0;
    reset_shadow();
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    key_pool[0] = '0; key_pool[1] = '1;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed
    push_cmd(OP_RM_HEAD, '0, '0, '0);            // key not active
    push_cmd(OP_PEEK, '1, '0, '0);
    push_cmd(OP_FIND_SEM, '1, '0, '0);
    push_cmd(OP_RM_PROC, '0, 5'd3, '0);         // slot not blocked
    push_cmd(OP_INSERT, '0, '0, '0);
    push_cmd(OP_INSERT, '0, '1, '1);
    push_cmd(OP_INSERT, '1, 5'd7, 31'h2aaaaaaa);
    push_cmd(OP_INSERT, '0, '1, 31'd5);          // already blocked
    push_cmd(OP_INSERT, '0, 5'd9, '1);          // duplicate pid
    push_cmd(OP_FIND_PID, '0, '0, '1);
    push_cmd(OP_FIND_PID, '0, '0, 31'd12345);
    push_cmd(OP_PEEK, '0, '0, '0);
    push_cmd(OP_FIND_SEM, '1, '0, '0);
    push_cmd(OP_RM_PROC, '0, '1, '0);           // unlink from the middle
    push_cmd(OP_RM_PROC, '0, 5'd9, '0);         // unlink the tail
    push_cmd(3'd6, '1, '1, '1);
    push_cmd(3'd7, '0, '0, '0);
    push_cmd(OP_RM_HEAD, '0, '0, '0);
    push_cmd(OP_RM_HEAD, '1, '0, '0);
    // exhaust the pool with distinct keys, remove every process again, then insert one more
    for (int i = 0; i < NP; i++) push_cmd(OP_INSERT, KEY_W'(32'h1000 + i), SLOT_W'(i), PID_W'(i));
    wait (pending_cmds.size() == 0 && expected_resps.size() == 0);
    for (int i = 0; i < NP; i++) push_cmd(OP_RM_PROC, '0, SLOT_W'(i), '0);
    push_cmd(OP_INSERT, 32'h5555aaaa, 5'd4, '0);

    // random
    for (int i = 0; i < 1800; i++) begin
      sel = $urandom_range(0, 99);
      k = (sel < 90) ? key_pool[$urandom_range(0, 7)] : $urandom();
      s = $urandom_range(0, 31);
      if (sel < 40) op = OP_INSERT;
      else if (sel < 58) op = OP_RM_HEAD;
      else if (sel < 76) op = OP_RM_PROC;
      else if (sel < 84) op = OP_PEEK;
      else if (sel < 92) op = OP_FIND_PID;
      else if (sel < 98) op = OP_FIND_SEM;
      else op = $urandom_range(6, 7);
      n = (sel % 3 == 0) ? $urandom() : $urandom_range(0, 40);
      push_cmd(OP_W'(op), k, SLOT_W'(s), PID_W'(n));
      if (i == 900) begin
        wait (pending_cmds.size() == 0);
        hold_off = 1;
      end
    end

    wait (pending_cmds.size() == 0 && expected_resps.size() == 0);
    repeat (6 * NP + 20) @(posedge clk);
    if (errors == 0) $display("tb_semaphore_blocked_queue_engine: PASS");
    else $display("tb_semaphore_blocked_queue_engine: FAIL");
    $finish;
  end
endmodule
